FILE: hw/rtl/tdc_event_word_decoder_unit_assert.svh
// Assertion macros for the converter readout decoder.
// Used by the top level; needs aclk and aresetn in scope.
`ifndef TDC_EVENT_WORD_DECODER_UNIT_ASSERT_SVH
`define TDC_EVENT_WORD_DECODER_UNIT_ASSERT_SVH

// Checked only out of reset
`define TDC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Checked through reset as well
`define TDC_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

FILE: hw/rtl/tdc_ewd_pkg.sv
// Shared types and constants for the converter readout decoder.
// No dependencies; imported by every module of the block.
`default_nettype none

package tdc_ewd_pkg;

    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 48;

    localparam logic [4:0] TYPE_HEADER = 5'd8;
    localparam logic [4:0] TYPE_HIT    = 5'd0;

    typedef enum logic {
        KIND_HIT = 1'b0,
        KIND_END = 1'b1
    } kind_t;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_BAD_HEADER = 2'd1,
        ST_EMPTY      = 2'd2,
        ST_STRAY      = 2'd3
    } status_t;

    typedef struct packed {
        kind_t         kind;
        logic [6:0]    channel;
        logic [18:0]   hit_time;
        logic [15:0]   event_number;
        status_t       status;
    } res_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

`default_nettype wire

FILE: hw/rtl/tdc_event_word_decoder_unit.sv
// Top level of the converter readout decoder: front end, result queue, output stage.
// Depends on tdc_ewd_pkg, tdc_ewd_front, tdc_ewd_queue, tdc_ewd_back and the assert header.
//
//   Stream   Dir   tuser            tdata
//   s_       in    is_descriptor    data_word[31:0]
//   m_       out   kind             channel, hit_time, event_number, status
//
// One word is taken per cycle while s_tready is high; the event state is registered.
// A result is queued as its word is accepted, then moved into the output register.
// Reset clears the event state, empties the queue and clears the output valid flag.
// s_tready drops only while both queue entries are held by a stalled output.
`default_nettype none

module tdc_event_word_decoder_unit (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic                                 s_tvalid,
    output logic                                      s_tready,
    input  wire logic [tdc_ewd_pkg::IN_DATA_W-1:0]    s_tdata,  // data_word[31:0]
    input  wire logic                                 s_tuser,  // is_descriptor
    output logic                                      m_tvalid,
    input  wire logic                                 m_tready,
    // channel[6:0], hit_time[25:7], event_number[41:26], status[43:42], zero[47:44]
    output logic [tdc_ewd_pkg::OUT_DATA_W-1:0]        m_tdata,
    output logic                                      m_tuser   // kind
);
    import tdc_ewd_pkg::*;

    `include "tdc_event_word_decoder_unit_assert.svh"

    logic      accept;
    logic      push;
    logic      pop;
    res_t      push_data;
    res_t      pop_data;
    res_t      out_data;
    q_status_t q_status;

    assign s_tready = !q_status.full;
    assign accept   = s_tvalid && s_tready;

    tdc_ewd_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .accept        (accept),
        .is_descriptor (s_tuser),
        .data_word     (s_tdata),
        .push_data     (push_data),
        .push          (push)
    );

    tdc_ewd_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .status    (q_status)
    );

    tdc_ewd_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .pop_data  (pop_data),
        .status    (q_status),
        .pop       (pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_data)
    );

    assign m_tuser = out_data.kind;
    assign m_tdata = {4'd0, out_data.status, out_data.event_number,
                      out_data.hit_time, out_data.channel};

    `TDC_ASSERT(a_no_push_when_full, q_status.full |-> !push, "push into full queue")
    `TDC_ASSERT(a_no_pop_when_empty, q_status.empty |-> !pop, "pop from empty queue")
    `TDC_ASSERT(a_hit_status_ok, (m_tvalid && m_tuser == KIND_HIT) |-> (m_tdata[43:42] == ST_OK), "hit with status")
    `TDC_ASSERT(a_end_no_hit_fields, (m_tvalid && m_tuser == KIND_END) |-> (m_tdata[25:0] == 26'd0), "end result with hit fields")
    `TDC_ASSERT_ALWAYS(a_reset_idle, !aresetn |=> (!m_tvalid && s_tready), "outputs not idle after reset")

endmodule

`default_nettype wire

FILE: hw/rtl/tdc_ewd_front.sv
// Front end: accepts readout words, tracks event state, builds results.
// Depends on tdc_ewd_pkg.
`default_nettype none

module tdc_ewd_front (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  accept,
    input  wire logic                  is_descriptor,
    input  wire logic [31:0]           data_word,
    output tdc_ewd_pkg::res_t          push_data,
    output logic                       push
);
    import tdc_ewd_pkg::*;

    logic [15:0] current_event_reg, current_event_next;
    logic [15:0] words_left_reg, words_left_next;
    logic        at_first_reg, at_first_next;
    logic        header_bad_reg, header_bad_next;

    logic [15:0] words_dec;
    logic        bad_now;
    logic [4:0]  word_type;
    res_t        res;
    logic        emit;

    assign word_type = data_word[31:27];
    assign words_dec = words_left_reg - 16'd1;
    assign bad_now   = at_first_reg
                     ? !(word_type == TYPE_HEADER &&
                         data_word[26:5] == {6'd0, current_event_reg})
                     : header_bad_reg;

    always_comb begin
        current_event_next = current_event_reg;
        words_left_next    = words_left_reg;
        at_first_next      = at_first_reg;
        header_bad_next    = header_bad_reg;
        emit               = 1'b0;
        res.kind           = KIND_END;
        res.channel        = 7'd0;
        res.hit_time       = 19'd0;
        res.event_number   = current_event_reg;
        res.status         = ST_OK;
        priority if (is_descriptor) begin
            current_event_next = data_word[31:16];
            words_left_next    = data_word[15:0];
            header_bad_next    = 1'b0;
            at_first_next      = (data_word[15:0] != 16'd0);
            res.event_number   = data_word[31:16];
            res.status         = ST_EMPTY;
            emit               = (data_word[15:0] == 16'd0);
        end else if (words_left_reg == 16'd0) begin
            // stray word: report, leave state alone
            res.status = ST_STRAY;
            emit       = 1'b1;
        end else begin
            header_bad_next = bad_now;
            at_first_next   = 1'b0;
            words_left_next = words_dec;
            if (words_dec == 16'd0) begin
                res.status = bad_now ? ST_BAD_HEADER : ST_OK;
                emit       = 1'b1;
            end else if (word_type == TYPE_HIT) begin
                res.kind     = KIND_HIT;
                res.channel  = data_word[25:19];
                res.hit_time = data_word[18:0];
                emit         = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            current_event_reg <= 16'd0;
            words_left_reg    <= 16'd0;
            at_first_reg      <= 1'b0;
            header_bad_reg    <= 1'b0;
        end else if (accept) begin
            current_event_reg <= current_event_next;
            words_left_reg    <= words_left_next;
            at_first_reg      <= at_first_next;
            header_bad_reg    <= header_bad_next;
        end
    end

    assign push      = accept && emit;
    assign push_data = res;

endmodule

`default_nettype wire

FILE: hw/rtl/tdc_ewd_queue.sv
// Two-entry result queue between the front end and the output stage.
// Depends on tdc_ewd_pkg.
`default_nettype none

module tdc_ewd_queue (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  push,
    input  tdc_ewd_pkg::res_t          push_data,
    input  wire logic                  pop,
    output tdc_ewd_pkg::res_t          pop_data,
    output tdc_ewd_pkg::q_status_t     status
);
    import tdc_ewd_pkg::*;

    res_t       mem [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            unique case ({push, pop})
                2'b10:   count_reg <= count_reg + 2'd1;
                2'b01:   count_reg <= count_reg - 2'd1;
                default: count_reg <= count_reg;
            endcase
        end
    end

    assign pop_data     = mem[rd_ptr_reg];
    assign status.full  = count_reg[1];
    assign status.empty = (count_reg == 2'd0);

endmodule

`default_nettype wire

FILE: hw/rtl/tdc_ewd_back.sv
// Output stage: moves queued results into the registered result stream.
// Depends on tdc_ewd_pkg.
`default_nettype none

module tdc_ewd_back (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  tdc_ewd_pkg::res_t          pop_data,
    input  tdc_ewd_pkg::q_status_t     status,
    output logic                       pop,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output tdc_ewd_pkg::res_t          out_data
);
    import tdc_ewd_pkg::*;

    res_t out_reg;
    logic valid_reg;

    // load when the register is free or being emptied this cycle
    assign pop = !status.empty && (!valid_reg || out_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (pop) begin
            valid_reg <= 1'b1;
        end else if (out_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            out_reg <= pop_data;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = out_reg;

endmodule

`default_nettype wire
